[rtl/sfx_pkg.sv]
// sfx_pkg: shared widths, constants, the foxhole table and the sequencer
// state type for the Shekel foxholes fitness block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfx_pkg;

  // Default gene width
  localparam int GENE_BITS_DEF = 17;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 18;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd1;
  localparam int OFS_W = 18;
  localparam logic signed [OFS_W-1:0] OFS_RESET = -18'sd65536;

  // Sixth-power datapath
  localparam int MAG_W  = 17;   // |difference| below the saturation point
  localparam int SQ_W   = 34;   // m^2
  localparam int CUBE_W = 51;   // m^3
  localparam int PROD_W = 68;   // multiplier product
  localparam int POW6_W = 102;  // m^6
  localparam int SIX_W  = 105;  // m^6 or the saturated value
  localparam logic [SIX_W-1:0] SAT6 = {1'b1, {(SIX_W-1){1'b0}}};

  // Division datapath
  localparam int BASE_W = 65;   // (j+1) * 1e18
  localparam int DEN_W  = 106;
  localparam int DIV_W  = 107;
  localparam int QUO_W  = 41;
  localparam int SUM_W  = 45;
  localparam int FIT_W  = 41;
  localparam logic [BASE_W-1:0] TEN18    = 65'd1000000000000000000;
  // 1e18 * 2^40 shifted down by the 41 quotient bits
  localparam logic [DIV_W-1:0]  FOX_INIT = 107'd500000000000000000;
  // 2^72 shifted down by the 41 quotient bits
  localparam logic [DIV_W-1:0]  FIN_INIT = 107'd2147483648;
  // floor(2^40 / 500)
  localparam logic [SUM_W-1:0]  SUM_INIT = 45'd2199023255;

  // Foxhole grid
  localparam int HOLE_IDX_W = 3;
  localparam logic [HOLE_IDX_W-1:0] HOLE_LAST = 3'd4;
  localparam int HOLE_N = 5;
  localparam int HOLE_W = 17;

  // Foxhole centre coordinate in thousandths
  function automatic logic signed [HOLE_W-1:0] hole_milli(input logic [HOLE_IDX_W-1:0] i);
    logic signed [HOLE_W-1:0] v;
    unique case (i)
      3'd0:    v = -17'sd32000;
      3'd1:    v = -17'sd16000;
      3'd2:    v = 17'sd0;
      3'd3:    v = 17'sd16000;
      3'd4:    v = 17'sd32000;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for start
    ST_HOLE,   // form |difference| for one axis/hole pair
    ST_SQ,     // m * m
    ST_CUBE,   // m * m^2
    ST_CAP,    // capture m^3
    ST_P6,     // one digit of m^3 times m^3
    ST_ACC,    // accumulate the partial product
    ST_DSUM,   // sixth(dx) + sixth(dy)
    ST_DDEN,   // add (j+1) * 1e18
    ST_DGO,    // launch foxhole division
    ST_DWAIT,  // wait for quotient, accumulate
    ST_FGO,    // launch final division
    ST_FWAIT   // wait for fitness
  } seq_state_t;

endpackage

`default_nettype wire

[rtl/sfx_mul.sv]
// sfx_mul: registered 17 x 51 bit unsigned multiplier, shared by all
// sixth-power steps. Depends on sfx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfx_mul (
  input  wire logic                       clk,
  input  wire logic [sfx_pkg::MAG_W-1:0]  a,
  input  wire logic [sfx_pkg::CUBE_W-1:0] b,
  output logic      [sfx_pkg::PROD_W-1:0] prod
);

  // One product per cycle, result registered
  always_ff @(posedge clk) begin
    prod <= sfx_pkg::PROD_W'(a) * sfx_pkg::PROD_W'(b);
  end

endmodule

`default_nettype wire

[rtl/sfx_div.sv]
// sfx_div: restoring divider, one quotient bit per cycle, low dividend
// bits known to be zero. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfx_div #(
  parameter int DW = 107,
  parameter int QW = 41
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [DW-1:0] init,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic      [QW-1:0] quo
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fit;

  // Shift in a zero, trial subtract
  always_comb begin
    trial = {rem, 1'b0};
    diff  = trial - {1'b0, dvs};
    fit   = (trial >= {1'b0, dvs});
  end

  // Iteration count and completion strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        cnt <= CNT_W'(QW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= init;
      dvs <= divisor;
      quo <= '0;
    end else if (cnt != '0) begin
      rem <= fit ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[QW-2:0], fit};
    end
  end

endmodule

`default_nettype wire

[rtl/shekel_foxholes_fitness.sv]
// shekel_foxholes_fitness: De Jong F5 fitness on one shared multiplier and one
// shared bit-serial divider. Depends on sfx_pkg, sfx_mul, sfx_div.
// Computes a sixth power for each in-range axis/hole pair (saturated otherwise),
// a division per foxhole and a final divide. One beat at a time; busy drops in
// the done cycle and the receiver cannot stall. Synchronous reset clears the
// sequencer, done strobe and configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module shekel_foxholes_fitness #(
  parameter int GENE_BITS = sfx_pkg::GENE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [GENE_BITS-1:0]          gene_x,
  input  wire logic [GENE_BITS-1:0]          gene_y,
  output logic                               done,
  output logic      [sfx_pkg::FIT_W-1:0]     fitness,
  input  wire logic                          wr_en,
  input  wire logic [sfx_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [sfx_pkg::CFG_W-1:0]     wr_data
);

  // Signed coordinate width: gene plus offset plus hole distance
  localparam int CW = ((GENE_BITS > sfx_pkg::OFS_W) ? GENE_BITS : sfx_pkg::OFS_W) + 2;

  sfx_pkg::seq_state_t state, state_next;

  // Configuration registers
  logic                            gray_coded;
  logic signed [sfx_pkg::OFS_W-1:0] center_offset;

  // Coordinates and sixth-power working registers
  logic signed [CW-1:0]               px, py;
  logic [sfx_pkg::HOLE_IDX_W-1:0]     idx;
  logic                               hsel;
  logic [sfx_pkg::MAG_W-1:0]          m;
  logic [sfx_pkg::CUBE_W-1:0]         c;
  logic [1:0]                         t;
  logic [sfx_pkg::POW6_W-1:0]         acc;
  logic [sfx_pkg::SIX_W-1:0]          sx [sfx_pkg::HOLE_N];
  logic [sfx_pkg::SIX_W-1:0]          sy [sfx_pkg::HOLE_N];

  // Division working registers
  logic [sfx_pkg::HOLE_IDX_W-1:0]     ix, iy;
  logic [sfx_pkg::DEN_W-1:0]          den;
  logic [sfx_pkg::BASE_W-1:0]         base;
  logic [sfx_pkg::SUM_W-1:0]          sum;

  // Shared unit hookup
  logic [sfx_pkg::MAG_W-1:0]          mul_a;
  logic [sfx_pkg::CUBE_W-1:0]         mul_b;
  logic [sfx_pkg::PROD_W-1:0]         prod;
  logic                               div_go;
  logic [sfx_pkg::DIV_W-1:0]          div_init;
  logic [sfx_pkg::DIV_W-1:0]          div_dvs;
  logic                               div_done;
  logic [sfx_pkg::QUO_W-1:0]          div_quo;

  // Combinational helpers
  logic [GENE_BITS-1:0]               bx, by;
  logic signed [CW-1:0]               dsel, dlt;
  logic [CW-1:0]                      ad;
  logic                               ovf;
  logic [sfx_pkg::MAG_W-1:0]          digit;
  logic [sfx_pkg::POW6_W-1:0]         p_sh;
  logic [sfx_pkg::POW6_W-1:0]         acc_sum;
  logic                               accept;
  logic                               six_last;
  logic                               fox_last;

  assign busy   = (state != sfx_pkg::ST_IDLE);
  assign accept = start && !busy;

  sfx_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  sfx_div #(
    .DW (sfx_pkg::DIV_W),
    .QW (sfx_pkg::QUO_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .init    (div_init),
    .divisor (div_dvs),
    .done    (div_done),
    .quo     (div_quo)
  );

  // Gray decode, MSB first: each bit is the parity of itself and all above
  always_comb begin
    for (int i = 0; i < GENE_BITS; i++) begin
      bx[i] = gray_coded ? ^(gene_x >> i) : gene_x[i];
      by[i] = gray_coded ? ^(gene_y >> i) : gene_y[i];
    end
  end

  // Distance to the current hole, magnitude and saturation
  always_comb begin
    dsel = hsel ? py : px;
    dlt  = dsel - CW'(sfx_pkg::hole_milli(idx));
    ad   = dlt[CW-1] ? (~dlt + 1'b1) : dlt;
    ovf  = |ad[CW-1:sfx_pkg::MAG_W];
  end

  // Digit of m^3 and shifted partial product
  always_comb begin
    unique case (t)
      2'd0:    digit = c[16:0];
      2'd1:    digit = c[33:17];
      2'd2:    digit = c[50:34];
      default: digit = '0;
    endcase
    unique case (t)
      2'd0:    p_sh = sfx_pkg::POW6_W'(prod);
      2'd1:    p_sh = sfx_pkg::POW6_W'({prod, 17'b0});
      2'd2:    p_sh = sfx_pkg::POW6_W'({prod, 34'b0});
      default: p_sh = '0;
    endcase
    acc_sum  = acc + p_sh;
    six_last = hsel && (idx == sfx_pkg::HOLE_LAST);
    fox_last = (ix == sfx_pkg::HOLE_LAST) && (iy == sfx_pkg::HOLE_LAST);
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      sfx_pkg::ST_IDLE:  if (start) state_next = sfx_pkg::ST_HOLE;
      sfx_pkg::ST_HOLE: begin
        if (!ovf)          state_next = sfx_pkg::ST_SQ;
        else if (six_last) state_next = sfx_pkg::ST_DSUM;
      end
      sfx_pkg::ST_SQ:    state_next = sfx_pkg::ST_CUBE;
      sfx_pkg::ST_CUBE:  state_next = sfx_pkg::ST_CAP;
      sfx_pkg::ST_CAP:   state_next = sfx_pkg::ST_P6;
      sfx_pkg::ST_P6:    state_next = sfx_pkg::ST_ACC;
      sfx_pkg::ST_ACC: begin
        if (t != 2'd2)     state_next = sfx_pkg::ST_P6;
        else if (six_last) state_next = sfx_pkg::ST_DSUM;
        else               state_next = sfx_pkg::ST_HOLE;
      end
      sfx_pkg::ST_DSUM:  state_next = sfx_pkg::ST_DDEN;
      sfx_pkg::ST_DDEN:  state_next = sfx_pkg::ST_DGO;
      sfx_pkg::ST_DGO:   state_next = sfx_pkg::ST_DWAIT;
      sfx_pkg::ST_DWAIT: begin
        if (div_done) state_next = fox_last ? sfx_pkg::ST_FGO : sfx_pkg::ST_DSUM;
      end
      sfx_pkg::ST_FGO:   state_next = sfx_pkg::ST_FWAIT;
      sfx_pkg::ST_FWAIT: if (div_done) state_next = sfx_pkg::ST_IDLE;
      default:           state_next = sfx_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: shared unit operands
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    div_go   = 1'b0;
    div_init = sfx_pkg::FOX_INIT;
    div_dvs  = sfx_pkg::DIV_W'(den);
    unique case (state)
      sfx_pkg::ST_SQ: begin
        mul_a = m;
        mul_b = sfx_pkg::CUBE_W'(m);
      end
      sfx_pkg::ST_CUBE: begin
        mul_a = m;
        mul_b = sfx_pkg::CUBE_W'(prod[sfx_pkg::SQ_W-1:0]);
      end
      sfx_pkg::ST_P6: begin
        mul_a = digit;
        mul_b = c;
      end
      sfx_pkg::ST_DGO: begin
        div_go = 1'b1;
      end
      sfx_pkg::ST_FGO: begin
        div_go   = 1'b1;
        div_init = sfx_pkg::FIN_INIT;
        div_dvs  = sfx_pkg::DIV_W'(sum);
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfx_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == sfx_pkg::ST_FWAIT) && div_done;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gray_coded    <= 1'b0;
      center_offset <= sfx_pkg::OFS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        sfx_pkg::REG_GRAY:   gray_coded    <= wr_data[0];
        sfx_pkg::REG_OFFSET: center_offset <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == sfx_pkg::ST_FWAIT && div_done) fitness <= div_quo;
    unique case (state)
      sfx_pkg::ST_IDLE: begin
        if (accept) begin
          px   <= $signed(CW'(bx)) + CW'(center_offset);
          py   <= $signed(CW'(by)) + CW'(center_offset);
          idx  <= '0;
          hsel <= 1'b0;
          ix   <= '0;
          iy   <= '0;
          base <= sfx_pkg::TEN18;
          sum  <= sfx_pkg::SUM_INIT;
        end
      end
      sfx_pkg::ST_HOLE: begin
        m <= ad[sfx_pkg::MAG_W-1:0];
        if (ovf) begin
          if (hsel) sy[idx] <= sfx_pkg::SAT6;
          else      sx[idx] <= sfx_pkg::SAT6;
          if (idx == sfx_pkg::HOLE_LAST) begin
            idx  <= '0;
            hsel <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
      sfx_pkg::ST_CAP: begin
        c   <= prod[sfx_pkg::CUBE_W-1:0];
        acc <= '0;
        t   <= 2'd0;
      end
      sfx_pkg::ST_ACC: begin
        acc <= acc_sum;
        t   <= t + 1'b1;
        if (t == 2'd2) begin
          if (hsel) sy[idx] <= sfx_pkg::SIX_W'(acc_sum);
          else      sx[idx] <= sfx_pkg::SIX_W'(acc_sum);
          if (idx == sfx_pkg::HOLE_LAST) begin
            idx  <= '0;
            hsel <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
      sfx_pkg::ST_DSUM: begin
        den <= sfx_pkg::DEN_W'(sx[ix]) + sfx_pkg::DEN_W'(sy[iy]);
      end
      sfx_pkg::ST_DDEN: begin
        den <= den + sfx_pkg::DEN_W'(base);
      end
      sfx_pkg::ST_DWAIT: begin
        if (div_done) begin
          sum  <= sum + sfx_pkg::SUM_W'(div_quo);
          base <= base + sfx_pkg::TEN18;
          if (ix == sfx_pkg::HOLE_LAST) begin
            ix <= '0;
            iy <= iy + 1'b1;
          end else begin
            ix <= ix + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
